// ===== rtl/weighted_random_peer_select_assert.svh =====
// Assertion macros used by the checker file of the peer selector.
`ifndef WEIGHTED_RANDOM_PEER_SELECT_ASSERT_SVH
`define WEIGHTED_RANDOM_PEER_SELECT_ASSERT_SVH

// A property that must hold in the same cycle as its condition.
`define WRPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A property that must hold in the cycle after its condition.
`define WRPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/wrps_pkg.sv =====
// Shared types, constants and command structures of the peer selector.
package wrps_pkg;

    // Default size of the weight table.
    localparam int MAX_PEERS_DEF = 64;

    // Field widths.
    localparam int PEER_W   = 6;
    localparam int WEIGHT_W = 16;
    localparam int DRAW_W   = 16;
    localparam int COUNT_W  = 7;
    localparam int CFG_AW   = 1;
    localparam int CFG_DW   = 7;

    // Stream packing widths.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;

    // Q8.8 value of 1.0, the reset weight of every peer.
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 16'd256;

    // Register reset values.
    localparam logic [COUNT_W-1:0] PEER_COUNT_RST = 7'd2;
    localparam logic [PEER_W-1:0]  OWN_RANK_RST   = 6'd0;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_PEER_COUNT = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_OWN_RANK   = 1'b1;

    // Request kinds carried in tuser.
    localparam logic KIND_UPDATE = 1'b0;
    localparam logic KIND_PICK   = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;      // latch draw, restart the table walk
        logic write;      // store the weight of an update request
        logic issue;      // read the next table entry
        logic accumulate; // add returned entries to the running sum
        logic scan;       // compare the running sum with the threshold
        logic mul;        // form the threshold, restart the table walk
        logic load;       // move the result into the output register
    } wrps_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic issue_done; // every active entry has been read
        logic rd_pend;    // a read is still returning data
        logic acc_zero;   // the running sum is zero
        logic hit;        // the scan has found a peer
        logic out_free;   // the output register can take a result
    } wrps_stat_t;

endpackage

// ===== rtl/wrps_ram.sv =====
// Generic simple dual-port RAM with a registered read port.
module wrps_ram
    import wrps_pkg::*;
#(
    parameter int WIDTH = WEIGHT_W,
    parameter int DEPTH = MAX_PEERS_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/wrps_ctrl.sv =====
// Controller of the peer selector: sequences the sum pass, threshold and scan pass.
module wrps_ctrl
    import wrps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       kind,
    input  wrps_stat_t stat,
    output logic       s_tready,
    output wrps_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_SCAN,
        ST_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (kind == KIND_PICK)
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SUM;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_SUM:
            begin
                cmd.issue      = !stat.issue_done;
                cmd.accumulate = 1'b1;
                if (stat.issue_done && !stat.rd_pend)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = stat.acc_zero ? ST_HOLD : ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.issue      = !stat.issue_done && !stat.hit;
                cmd.accumulate = 1'b1;
                cmd.scan       = 1'b1;
                if (stat.hit || (stat.issue_done && !stat.rd_pend))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (stat.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/wrps_dp.sv =====
// Datapath of the peer selector: weight table, table walk, threshold and output register.
module wrps_dp
    import wrps_pkg::*;
#(
    parameter int MAX_PEERS = MAX_PEERS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  wrps_cmd_t           cmd,
    output wrps_stat_t          stat,
    input  logic                cfg_we,
    input  logic [CFG_AW-1:0]   cfg_addr,
    input  logic [CFG_DW-1:0]   cfg_data,
    input  logic [PEER_W-1:0]   in_peer,
    input  logic [WEIGHT_W-1:0] in_weight,
    input  logic [DRAW_W-1:0]   in_draw,
    input  logic                m_tready,
    output logic                out_valid,
    output logic [PEER_W-1:0]   chosen_peer,
    output logic                found
);

    // Only indices below 128 can ever be active, as the count register has seven bits.
    localparam int DEPTH = (MAX_PEERS < 128) ? MAX_PEERS : 128;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int TW    = WEIGHT_W + AW;

    logic [COUNT_W-1:0]  peer_count_reg;
    logic [PEER_W-1:0]   own_rank_reg;
    logic [CW-1:0]       active_n;

    logic [DEPTH-1:0]    valid_reg;
    logic                valid_rd_reg;
    logic [WEIGHT_W-1:0] ram_q;
    logic [WEIGHT_W-1:0] entry_w;
    logic                wr_en;

    logic [CW-1:0]       issue_cnt_reg;
    logic                rd_pend_reg;
    logic [AW-1:0]       rd_idx_reg;
    logic [TW-1:0]       acc_reg;
    logic [TW-1:0]       acc_sum;
    logic                take;
    logic [DRAW_W-1:0]   draw_reg;
    logic [TW-1:0]       thr_reg;
    logic [TW+DRAW_W-1:0] prod;
    logic                hit_reg;
    logic [AW-1:0]       hit_idx_reg;

    logic                out_valid_reg;
    logic [PEER_W-1:0]   chosen_reg;
    logic                found_reg;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peer_count_reg <= PEER_COUNT_RST;
            own_rank_reg   <= OWN_RANK_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_PEER_COUNT: peer_count_reg <= cfg_data;
                CFG_OWN_RANK:   own_rank_reg   <= cfg_data[PEER_W-1:0];
                default:        ;
            endcase
        end
    end

    // Effective peer count, limited by the table size.
    assign active_n = ({1'b0, peer_count_reg} > 8'(DEPTH)) ? CW'(DEPTH) : CW'(peer_count_reg);

    // An update at or beyond the active count is dropped.
    assign wr_en = cmd.write && ({2'b00, in_peer} < 8'(active_n));

    // Weight table.
    wrps_ram #(
        .WIDTH (WEIGHT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (AW'(in_peer)),
        .wdata (in_weight),
        .re    (cmd.issue),
        .raddr (issue_cnt_reg[AW-1:0]),
        .rdata (ram_q)
    );

    // Written marks: an entry never written reads as 1.0.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[AW'(in_peer)] <= 1'b1;
        end
    end

    assign entry_w = valid_rd_reg ? ram_q : WEIGHT_ONE;
    assign acc_sum = acc_reg + TW'(entry_w);

    // Returned entry takes part unless it is the own rank.
    assign take = rd_pend_reg && cmd.accumulate && !hit_reg
                  && (8'(rd_idx_reg) != {2'b00, own_rank_reg});

    assign prod = (TW+DRAW_W)'(draw_reg) * (TW+DRAW_W)'(acc_reg);

    // Table walk control: read counter, read pipeline, running sum and hit flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg <= '0;
            rd_pend_reg   <= 1'b0;
            acc_reg       <= '0;
            hit_reg       <= 1'b0;
        end
        else if (cmd.start || cmd.mul)
        begin
            issue_cnt_reg <= '0;
            rd_pend_reg   <= 1'b0;
            acc_reg       <= '0;
            hit_reg       <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= cmd.issue;
            if (cmd.issue)
            begin
                issue_cnt_reg <= issue_cnt_reg + CW'(1);
            end
            if (take)
            begin
                acc_reg <= acc_sum;
                if (cmd.scan && (acc_sum > thr_reg))
                begin
                    hit_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers of the walk.
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_idx_reg   <= issue_cnt_reg[AW-1:0];
            valid_rd_reg <= valid_reg[issue_cnt_reg[AW-1:0]];
        end
        if (cmd.start)
        begin
            draw_reg <= in_draw;
        end
        if (cmd.mul)
        begin
            thr_reg <= prod[TW+DRAW_W-1:DRAW_W];
        end
        if (take && cmd.scan && (acc_sum > thr_reg))
        begin
            hit_idx_reg <= rd_idx_reg;
        end
    end

    // Output register: holds a result until the consumer takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            chosen_reg <= hit_reg ? PEER_W'(hit_idx_reg) : '0;
            found_reg  <= hit_reg;
        end
    end

    // Status to the controller.
    assign stat.issue_done = (issue_cnt_reg == active_n);
    assign stat.rd_pend    = rd_pend_reg;
    assign stat.acc_zero   = (acc_reg == '0);
    assign stat.hit        = hit_reg;
    assign stat.out_free   = !out_valid_reg || m_tready;

    assign out_valid   = out_valid_reg;
    assign chosen_peer = chosen_reg;
    assign found       = found_reg;

endmodule

// ===== rtl/weighted_random_peer_select.sv =====
// Top level of the weighted random peer selector.
//
// Channel  Direction  Handshake          Contents
// s_*      in         s_tvalid/s_tready  update or pick request
// m_*      out        m_tvalid/m_tready  selected peer and found flag
// cfg_*    in         cfg_we             peer_count, own_rank
//
// An update request leaves the block ready for the next request. A pick request
// walks the n active table entries twice through the single read port of the
// weight table, once to sum and once to find the prefix, and takes no new
// request until its result is loaded. A finished result waits in the output
// register while the next request is accepted. Reset sets every weight to 1.0,
// the count to two and the own rank to zero, and the block is ready at once.
module weighted_random_peer_select
    import wrps_pkg::*;
#(
    parameter int MAX_PEERS = MAX_PEERS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // peer[5:0], weight[21:6], draw[37:22], zero pad
    input  logic                 s_tuser,  // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // chosen_peer[5:0], zero pad
    output logic                 m_tuser,  // found
    input  logic                 cfg_we,
    input  logic [CFG_AW-1:0]    cfg_addr,
    input  logic [CFG_DW-1:0]    cfg_data
);

    wrps_cmd_t         cmd;
    wrps_stat_t        stat;
    logic [PEER_W-1:0] chosen_peer;

    // Sequencer.
    wrps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .kind     (s_tuser),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    // Weight table and arithmetic.
    wrps_dp #(
        .MAX_PEERS (MAX_PEERS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .in_peer     (s_tdata[5:0]),
        .in_weight   (s_tdata[21:6]),
        .in_draw     (s_tdata[37:22]),
        .m_tready    (m_tready),
        .out_valid   (m_tvalid),
        .chosen_peer (chosen_peer),
        .found       (m_tuser)
    );

    assign m_tdata = {2'b00, chosen_peer};

endmodule

// ===== rtl/wrps_chk.sv =====
// Port checker of the peer selector and its binding to the top level.
`include "weighted_random_peer_select_assert.svh"

module wrps_chk
    import wrps_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // A pick request occupies the block for at least the next cycle.
    `WRPS_ASSERT_NEXT(a_pick_busy, clk, rst_n, s_tvalid && s_tready && (s_tuser == KIND_PICK), !s_tready, "pick request did not block the input")

    // An update request leaves the block ready.
    `WRPS_ASSERT_NEXT(a_update_ready, clk, rst_n, s_tvalid && s_tready && (s_tuser == KIND_UPDATE), s_tready, "update request blocked the input")

    // A result without a peer carries index zero.
    `WRPS_ASSERT_NOW(a_none_zero, clk, rst_n, m_tvalid && !m_tuser, m_tdata == '0, "not-found result carries a nonzero index")

    // A stalled result holds.
    `WRPS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

endmodule

bind weighted_random_peer_select wrps_chk u_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
